// File: rtl/wsd_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
package wsd_pkg;

  // Event codes carried on event_res.
  typedef enum logic [1:0] {
    EV_DATA  = 2'd0,
    EV_EMPTY = 2'd1,
    EV_CLOSE = 2'd2
  } event_t;

  // Opcode of a close frame.
  localparam logic [3:0] OPC_CLOSE = 4'h8;

  // Seven-bit length codes that announce extended length bytes.
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // Number of extended length bytes for each code, and masking key bytes.
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  // One parse result handed from the parser to the output register.
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic [3:0] opcode;
    logic       last;
    event_t     ev;
  } res_t;

endpackage

// File: rtl/websocket_frame_deframer_core.sv
// Top level of the WebSocket frame deframer: input register, parser, output register.
// Usage:
//   Received bytes enter on the input channel (in_valid, in_ready, rx_byte), one word
//   per accepted handshake. Results leave on the output channel (out_valid, out_ready,
//   data_byte, frame_opcode, last_of_frame, event_res). Header, extended length and
//   masking key bytes produce no result word; each payload byte of a non-close frame
//   produces one unmasked data word, a zero-length non-close frame produces one
//   empty-frame event, and a close frame produces one close event after its payload,
//   after which all input is dropped.
//   Path: a byte waits in the input register, then its result is held in the output
//   register until the receiver takes it.
//   Throughput: one byte per cycle while the output is not stalled; the 64-bit length
//   count and the 8-bit unmasking XOR are combinational between the two registers.
//   Reset: the parser waits for the first header byte with the link open, and both
//   registers are empty.
//   Stall: while the receiver holds out_ready low with a word waiting, the parser
//   keeps its byte and the input register accepts at most one more byte.
module websocket_frame_deframer_core import wsd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] data_byte,
  output logic [3:0] frame_opcode,
  output logic       last_of_frame,
  output logic [1:0] event_res
);

  logic       in_reg_valid;
  logic [7:0] in_reg_byte;
  logic       take;
  res_t       res;

  // The held byte is consumed when the output register is free or being emptied.
  assign take     = in_reg_valid && (!out_valid || out_ready);
  assign in_ready = !in_reg_valid || take;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_ready) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_reg_byte <= rx_byte;
    end
  end

  wsd_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .byte_in (in_reg_byte),
    .res     (res)
  );

  wsd_out_reg u_out_reg (
    .clk           (clk),
    .rst           (rst),
    .load          (take),
    .res           (res),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .data_byte     (data_byte),
    .frame_opcode  (frame_opcode),
    .last_of_frame (last_of_frame),
    .event_res     (event_res)
  );

  // A waiting result blocks the parser, so a held byte cannot pass it.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready && in_reg_valid) |=> in_reg_valid && $stable(in_reg_byte))
    else $error("held byte lost while output stalled");

  // The output only fills from a consumed byte.
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(take))
    else $error("result word appeared without a consumed byte");

  // A waiting word is never overwritten.
  a_out_keep: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(data_byte) && $stable(event_res))
    else $error("stalled result word changed");

endmodule

// File: rtl/wsd_parser.sv
// Frame parser: header, extended length, masking key and payload tracking.
module wsd_parser import wsd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] byte_in,
  output res_t       res
);

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_KEY  = 3'd3,
    PH_DATA = 3'd4
  } phase_t;

  phase_t      phase, phase_next;
  logic [3:0]  cur_opcode, cur_opcode_next;
  logic        mask_present, mask_present_next;
  logic [63:0] remaining_length, remaining_length_next;
  logic [3:0]  header_byte_count, header_byte_count_next;
  logic [31:0] mask_key, mask_key_next;
  logic [1:0]  key_index, key_index_next;
  logic        link_open, link_open_next;

  logic        len_fin;
  logic        hdr_fin;
  logic [6:0]  len7;
  logic [7:0]  key_byte;
  logic        last;

  // Next state and the result for the byte in the input register.
  always_comb begin
    phase_next             = phase;
    cur_opcode_next        = cur_opcode;
    mask_present_next      = mask_present;
    remaining_length_next  = remaining_length;
    header_byte_count_next = header_byte_count;
    mask_key_next          = mask_key;
    key_index_next         = key_index;
    link_open_next         = link_open;
    len_fin                = 1'b0;
    hdr_fin                = 1'b0;
    len7                   = byte_in[6:0];
    key_byte               = 8'h00;
    last                   = 1'b0;
    res                    = '0;
    res.opcode             = cur_opcode;

    if (link_open) begin
      unique case (phase)
        PH_HDR1: begin
          mask_present_next     = byte_in[7];
          mask_key_next         = '0;
          remaining_length_next = '0;
          if (len7 == LEN_EXT16) begin
            header_byte_count_next = EXT16_BYTES;
            phase_next             = PH_EXT;
          end else if (len7 == LEN_EXT64) begin
            header_byte_count_next = EXT64_BYTES;
            phase_next             = PH_EXT;
          end else begin
            remaining_length_next = {57'd0, len7};
            len_fin               = 1'b1;
          end
        end
        PH_EXT: begin
          remaining_length_next  = {remaining_length[55:0], byte_in};
          header_byte_count_next = header_byte_count - 4'd1;
          len_fin                = (header_byte_count_next == 4'd0);
        end
        PH_KEY: begin
          mask_key_next          = {mask_key[23:0], byte_in};
          header_byte_count_next = header_byte_count - 4'd1;
          hdr_fin                = (header_byte_count_next == 4'd0);
        end
        PH_DATA: begin
          unique case (key_index)
            2'd0:    key_byte = mask_key[31:24];
            2'd1:    key_byte = mask_key[23:16];
            2'd2:    key_byte = mask_key[15:8];
            default: key_byte = mask_key[7:0];
          endcase
          key_index_next        = key_index + 2'd1;
          remaining_length_next = remaining_length - 64'd1;
          last                  = (remaining_length_next == 64'd0);
          if (last) begin
            phase_next = PH_HDR0;
          end
          if (cur_opcode == OPC_CLOSE) begin
            // A close frame swallows its payload and reports at the end.
            if (last) begin
              link_open_next = 1'b0;
              res.valid      = 1'b1;
              res.last       = 1'b1;
              res.ev         = EV_CLOSE;
            end
          end else begin
            res.valid = 1'b1;
            res.data  = byte_in ^ key_byte;
            res.last  = last;
            res.ev    = EV_DATA;
          end
        end
        default: begin
          // First header byte; unused phase codes land here as well.
          cur_opcode_next = byte_in[3:0];
          phase_next      = PH_HDR1;
        end
      endcase

      // Length complete: fetch the key if the frame is masked.
      if (len_fin) begin
        if (mask_present_next) begin
          phase_next             = PH_KEY;
          header_byte_count_next = KEY_BYTES;
          mask_key_next          = '0;
        end else begin
          hdr_fin = 1'b1;
        end
      end

      // Header complete: start the payload or close out an empty frame.
      if (hdr_fin) begin
        key_index_next = '0;
        if (remaining_length_next != 64'd0) begin
          phase_next = PH_DATA;
        end else begin
          phase_next = PH_HDR0;
          res.valid  = 1'b1;
          res.last   = 1'b1;
          if (cur_opcode == OPC_CLOSE) begin
            link_open_next = 1'b0;
            res.ev         = EV_CLOSE;
          end else begin
            res.ev = EV_EMPTY;
          end
        end
      end
    end
  end

  // Parser state advances only when the word in the input register is consumed.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HDR0;
      cur_opcode        <= '0;
      mask_present      <= 1'b0;
      remaining_length  <= '0;
      header_byte_count <= '0;
      mask_key          <= '0;
      key_index         <= '0;
      link_open         <= 1'b1;
    end else if (take) begin
      phase             <= phase_next;
      cur_opcode        <= cur_opcode_next;
      mask_present      <= mask_present_next;
      remaining_length  <= remaining_length_next;
      header_byte_count <= header_byte_count_next;
      mask_key          <= mask_key_next;
      key_index         <= key_index_next;
      link_open         <= link_open_next;
    end
  end

  // A closed link produces nothing.
  a_closed_silent: assert property (@(posedge clk) disable iff (rst)
    !link_open |-> !res.valid)
    else $error("result produced on a closed link");

  // A consumed close event shuts the link.
  a_close_shuts: assert property (@(posedge clk) disable iff (rst)
    (take && res.valid && res.ev == EV_CLOSE) |=> !link_open)
    else $error("link still open after close event");

  // Events always end their frame.
  a_event_last: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.ev != EV_DATA) |-> res.last)
    else $error("event result not marked last");

  // Payload is only tracked with a nonzero count.
  a_data_len: assert property (@(posedge clk) disable iff (rst)
    (link_open && phase == PH_DATA) |-> remaining_length != 64'd0)
    else $error("payload phase with zero remaining length");

endmodule

// File: rtl/wsd_out_reg.sv
// Output register that holds one result word until the receiver takes it.
module wsd_out_reg import wsd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  res_t       res,
  input  logic       out_ready,
  output logic       out_valid,
  output logic [7:0] data_byte,
  output logic [3:0] frame_opcode,
  output logic       last_of_frame,
  output logic [1:0] event_res
);

  // Valid flag: set by a loaded result, cleared once the word is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= res.valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Payload is captured along with the valid flag.
  always_ff @(posedge clk) begin
    if (load) begin
      data_byte     <= res.data;
      frame_opcode  <= res.opcode;
      last_of_frame <= res.last;
      event_res     <= res.ev;
    end
  end

endmodule
